// ----- rtl/core/ffba_pkg.sv -----
// package: shared types and constants of the first-fit block allocator
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_MARK,
      ST_REL_READ,
      ST_REL_CHECK,
      ST_FREE,
      ST_DONE
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic prep;
      logic scan_step;
      logic mark_start;
      logic mark_step;
      logic rel_read;
      logic free_start;
      logic free_step;
      logic set_fail;
      logic set_unknown;
      logic set_ok;
      logic rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic is_release;
      logic alloc_bad;
      logic scan_found;
      logic scan_end;
      logic mark_done;
      logic rel_bad;
      logic free_done;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_if.sv -----
// interfaces: request and response channels
`timescale 1ns / 1ps
`default_nettype none
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] request_bytes;
   logic [15:0] payload_offset;
   modport source (output valid, action, request_bytes, payload_offset, input ready);
   modport sink   (input valid, action, request_bytes, payload_offset, output ready);
endinterface

interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] granted_offset;
   modport source (output valid, status, granted_offset, input ready);
   modport sink   (input valid, status, granted_offset, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ffba_ctrl.sv -----
// controller: sequences clear, scan, mark, release and response
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire                     rsp_busy,
   input  ffba_pkg::dp_status_type sts,
   output ffba_pkg::dp_cmd_type    cmd
);
   ffba_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ffba_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffba_pkg::ST_CLEAR:     if (sts.clear_done) state_in = ffba_pkg::ST_IDLE;
         ffba_pkg::ST_IDLE:      if (req_valid) state_in = ffba_pkg::ST_PREP;
         ffba_pkg::ST_PREP: begin
            if (sts.is_release)     state_in = ffba_pkg::ST_REL_READ;
            else if (sts.alloc_bad) state_in = ffba_pkg::ST_DONE;
            else                    state_in = ffba_pkg::ST_SCAN;
         end
         ffba_pkg::ST_SCAN: begin
            if (sts.scan_found)    state_in = ffba_pkg::ST_MARK;
            else if (sts.scan_end) state_in = ffba_pkg::ST_DONE;
         end
         ffba_pkg::ST_MARK:      if (sts.mark_done) state_in = ffba_pkg::ST_DONE;
         ffba_pkg::ST_REL_READ:  state_in = ffba_pkg::ST_REL_CHECK;
         ffba_pkg::ST_REL_CHECK: begin
            if (sts.rel_bad) state_in = ffba_pkg::ST_DONE;
            else             state_in = ffba_pkg::ST_FREE;
         end
         ffba_pkg::ST_FREE:      if (sts.free_done) state_in = ffba_pkg::ST_DONE;
         ffba_pkg::ST_DONE:      if (!rsp_busy) state_in = ffba_pkg::ST_IDLE;
         default:                state_in = ffba_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ffba_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         ffba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ffba_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            if (!sts.is_release && sts.alloc_bad) cmd.set_fail = 1'b1;
         end
         ffba_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_found)    cmd.mark_start = 1'b1;
            else if (sts.scan_end) cmd.set_fail = 1'b1;
         end
         ffba_pkg::ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_done) cmd.set_ok = 1'b1;
         end
         ffba_pkg::ST_REL_READ: cmd.rel_read = 1'b1;
         ffba_pkg::ST_REL_CHECK: begin
            if (sts.rel_bad) cmd.set_unknown = 1'b1;
            else             cmd.free_start = 1'b1;
         end
         ffba_pkg::ST_FREE: begin
            cmd.free_step = 1'b1;
            if (sts.free_done) cmd.set_ok = 1'b1;
         end
         ffba_pkg::ST_DONE: cmd.rsp_load = !rsp_busy;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/core/ffba_dp.sv -----
// datapath: used bitmap, segment length memory, scan and release logic
`timescale 1ns / 1ps
`default_nettype none
module ffba_dp #(
   parameter int NUM_BLOCKS   = 1024,
   parameter int BLOCK_BYTES  = 64,
   parameter int HEADER_BYTES = 24
) (
   input  wire                      clock,
   input  wire                      reset,
   input  ffba_pkg::dp_cmd_type     cmd,
   output ffba_pkg::dp_status_type  sts,
   input  wire                      in_action,
   input  wire  [31:0]              in_request_bytes,
   input  wire  [15:0]              in_payload_offset,
   input  wire  [10:0]              heap_blocks,
   output logic [1:0]               res_status,
   output logic [15:0]              res_offset
);
   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int CW = IW + 1;
   localparam int BSH = $clog2(BLOCK_BYTES);
   localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);

   logic used_mem [NUM_BLOCKS];
   logic [10:0] seg_mem [NUM_BLOCKS];

   logic          act_ff;
   logic [31:0]   bytes_ff;
   logic [15:0]   off_ff;
   logic [CW-1:0] limit_ff, need_ff;
   logic [CW-1:0] idx_ff, run_ff, start_ff, end_ff;
   logic [10:0]   seg_rd_ff;
   logic          rel_bad_ff;
   logic [IW-1:0] rel_idx_ff;
   logic          used_rd_ff;
   logic [1:0]    status_ff;
   logic [15:0]   gofs_ff;

   // rounded block count of the request plus header
   logic [32:0] total;
   logic [32:0] need_full;
   assign total     = {1'b0, bytes_ff} + 33'(HEADER_BYTES);
   assign need_full = (total >> BSH) + 33'(|total[BSH-1:0]);

   // release offset decode
   logic [15:0] rel;
   logic        rel_fmt_bad;
   logic [15:0] rel_idx_full;
   assign rel = off_ff - 16'(HEADER_BYTES);
   assign rel_idx_full = rel >> BSH;
   assign rel_fmt_bad = ({16'd0, off_ff} < 32'(HEADER_BYTES)) || (|rel[BSH-1:0])
                        || ({16'd0, rel_idx_full} >= 32'(NUM_BLOCKS));

   logic [CW-1:0] lim_w;
   always_comb begin
      if (heap_blocks == 11'd0) lim_w = CW'(1);
      else if ({21'd0, heap_blocks} > 32'(NUM_BLOCKS)) lim_w = NB;
      else lim_w = CW'(heap_blocks);
   end

   logic [CW-1:0] run_nx;
   assign run_nx = run_ff + CW'(1);

   assign sts.clear_done = (idx_ff == NB - CW'(1));
   assign sts.is_release = act_ff;
   assign sts.alloc_bad  = (bytes_ff == 32'd0) || (|(need_full >> CW))
                           || (need_full[CW-1:0] > limit_ff);
   assign sts.scan_found = !used_rd_ff && (run_nx >= need_ff);
   assign sts.scan_end   = (idx_ff == limit_ff - CW'(1));
   assign sts.mark_done  = (idx_ff == end_ff - CW'(1));
   assign sts.rel_bad    = rel_bad_ff || (seg_rd_ff == 11'd0);
   assign sts.free_done  = (idx_ff == end_ff - CW'(1)) || (idx_ff == NB - CW'(1));

   // request capture and size precompute
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= in_action;
         bytes_ff <= in_request_bytes;
         off_ff   <= in_payload_offset;
         limit_ff <= lim_w;
      end
      if (cmd.prep) begin
         need_ff     <= need_full[CW-1:0];
         rel_bad_ff  <= rel_fmt_bad;
         rel_idx_ff  <= rel_idx_full[IW-1:0];
      end
   end

   // index and run counters
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.clear_step) begin
         idx_ff <= sts.clear_done ? '0 : idx_ff + CW'(1);
      end else if (cmd.prep) begin
         idx_ff <= '0;
         run_ff <= '0;
      end else if (cmd.scan_step) begin
         if (used_rd_ff) run_ff <= '0;
         else begin
            if (run_ff == '0) start_ff <= idx_ff;
            run_ff <= run_nx;
         end
         if (cmd.mark_start) begin
            idx_ff <= (run_ff == '0) ? idx_ff : start_ff;
            end_ff <= ((run_ff == '0) ? idx_ff : start_ff) + need_ff;
         end else idx_ff <= idx_ff + CW'(1);
      end else if (cmd.mark_step || cmd.free_step) begin
         idx_ff <= idx_ff + CW'(1);
      end else if (cmd.free_start) begin
         idx_ff <= CW'(rel_idx_ff);
         end_ff <= CW'(rel_idx_ff) + CW'(seg_rd_ff);
      end
   end

   // bitmap read port, one block per cycle
   logic [IW-1:0] rd_addr;
   assign rd_addr = cmd.scan_step ? IW'(idx_ff + CW'(1)) : '0;
   always_ff @(posedge clock) begin
      used_rd_ff <= used_mem[rd_addr];
   end

   // bitmap write port
   always_ff @(posedge clock) begin
      if (cmd.clear_step)     used_mem[idx_ff[IW-1:0]] <= 1'b0;
      else if (cmd.mark_step) used_mem[idx_ff[IW-1:0]] <= 1'b1;
      else if (cmd.free_step) used_mem[idx_ff[IW-1:0]] <= 1'b0;
   end

   // segment length memory
   always_ff @(posedge clock) begin
      if (cmd.clear_step)      seg_mem[idx_ff[IW-1:0]] <= 11'd0;
      else if (cmd.mark_start) seg_mem[IW'((run_ff == '0) ? idx_ff : start_ff)]
                                  <= 11'(need_ff);
      else if (cmd.free_start) seg_mem[rel_idx_ff] <= 11'd0;
      if (cmd.rel_read) seg_rd_ff <= seg_mem[rel_idx_ff];
   end

   // result
   always_ff @(posedge clock) begin
      if (cmd.set_fail) begin
         status_ff <= ffba_pkg::STATUS_NOSPACE;
         gofs_ff <= '0;
      end else if (cmd.set_unknown) begin
         status_ff <= ffba_pkg::STATUS_UNKNOWN;
         gofs_ff <= '0;
      end else if (cmd.set_ok) begin
         status_ff <= ffba_pkg::STATUS_OK;
         gofs_ff <= act_ff ? 16'd0
                    : 16'((32'(start_ff) << BSH) + 32'(HEADER_BYTES));
      end
   end
   assign res_status = status_ff;
   assign res_offset = gofs_ff;
endmodule
`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_top.sv -----
// top level: first-fit block allocator with request/response channels
// throughput: one request at a time; the serial bitmap scan (one block a cycle) sets the rate
// reset: synchronous; after reset a clearing pass over all NUM_BLOCKS blocks runs before requests
// configuration writes are taken at any time, including during the clearing pass
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_top #(
   parameter int NUM_BLOCKS   = 1024,
   parameter int BLOCK_BYTES  = 64,
   parameter int HEADER_BYTES = 24
) (
   input  wire          clock,
   input  wire          reset,
   ffba_req_if.sink     req,
   ffba_rsp_if.source   rsp,
   input  wire          csr_we,
   input  wire  [10:0]  csr_wdata
);
   ffba_pkg::dp_cmd_type    cmd;
   ffba_pkg::dp_status_type sts;
   logic [10:0] heap_blocks_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff, res_status;
   logic [15:0] rsp_offset_ff, res_offset;

   // heap size register
   always_ff @(posedge clock) begin
      if (reset) heap_blocks_ff <= 11'd1024;
      else if (csr_we) heap_blocks_ff <= csr_wdata;
   end

   ffba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_busy(rsp_valid_ff && !rsp.ready), .sts(sts), .cmd(cmd)
   );

   ffba_dp #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES),
             .HEADER_BYTES(HEADER_BYTES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_action(req.action), .in_request_bytes(req.request_bytes),
      .in_payload_offset(req.payload_offset), .heap_blocks(heap_blocks_ff),
      .res_status(res_status), .res_offset(res_offset)
   );

   // response output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_offset_ff <= res_offset;
      end
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.granted_offset = rsp_offset_ff;
endmodule
`default_nettype wire

// ----- rtl/core/ffba_checker.sv -----
// checker: port-level properties of the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ffba_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [15:0] rsp_granted_offset
);
   // a pending response holds steady
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");
   // a pending offset holds steady
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_granted_offset))
      else $error("offset changed while stalled");
   // status is a defined code
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");
   // failures carry a zero offset
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'd0 |-> rsp_granted_offset == 16'd0)
      else $error("offset on failure");
endmodule

bind first_fit_block_allocator_top ffba_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_granted_offset(rsp.granted_offset)
);
`default_nettype wire
